>>> design/rtu_frame_checker_macros.svh
// ----------------------------------------------------------------------------
// rtu_frame_checker_macros.svh
// Assertion macros for the RTU frame checker.
// ----------------------------------------------------------------------------
`ifndef RTU_FRAME_CHECKER_MACROS_SVH
`define RTU_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RTUFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtu_frame_checker assertion failed");

// Next-cycle implication, checked outside reset.
`define RTUFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtu_frame_checker assertion failed");

`endif

>>> design/rtufc_pkg.sv
// ----------------------------------------------------------------------------
// rtufc_pkg
// Shared types, constants and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package rtufc_pkg;

  localparam int unsigned MIN_FRAME    = 4;
  localparam int unsigned HEADER_BYTES = 2;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd252;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_BAD_CRC  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    logic [7:0] unit_id;
    logic [7:0] func_code;
    logic [7:0] payload_len;
    logic [1:0] status;
  } rtufc_result_t;

  // Reflected CRC-16, one byte folded in over eight bit steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> design/rtufc_frame_state.sv
// ----------------------------------------------------------------------------
// rtufc_frame_state
// Per-frame state (CRC, byte count, two-byte delay, header) and result logic.
// ----------------------------------------------------------------------------
module rtufc_frame_state #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [7:0]              cfg_wr_data,
  input  logic                    step,
  input  logic [7:0]              rx_byte,
  input  logic                    frame_end,
  output rtufc_pkg::rtufc_result_t result
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;

  logic [7:0]       max_payload_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       older_r, newer_r, unit_r, func_r;

  logic             first_byte, second_byte, in_body, releasing;
  logic [CMP_W-1:0] plen;

  assign first_byte  = (cnt_r == '0);
  assign second_byte = (cnt_r == CNT_W'(1));
  assign in_body     = (cnt_r >= CNT_W'(rtufc_pkg::HEADER_BYTES));
  assign releasing   = (cnt_r >= CNT_W'(rtufc_pkg::MIN_FRAME));

  always_comb begin
    crc_nxt = crc_r;
    if (!in_body) begin
      crc_nxt = rtufc_pkg::crc_byte(crc_r, rx_byte);
    end else if (releasing) begin
      crc_nxt = rtufc_pkg::crc_byte(crc_r, older_r);
    end
    cnt_nxt = (cnt_r < CNT_W'(MAX_FRAME)) ? cnt_r + 1'b1 : CNT_W'(MAX_FRAME);
  end

  assign plen = CMP_W'(cnt_nxt) - CMP_W'(rtufc_pkg::MIN_FRAME);

  always_comb begin
    result               = '0;
    result.payload_valid = releasing;
    result.payload_byte  = releasing ? older_r : 8'h00;
    if (frame_end) begin
      result.frame_done = 1'b1;
      result.unit_id    = first_byte ? rx_byte : unit_r;
      result.func_code  = first_byte ? 8'h00 : (second_byte ? rx_byte : func_r);
      if (cnt_nxt < CNT_W'(rtufc_pkg::MIN_FRAME)) begin
        result.status = rtufc_pkg::ST_SHORT;
      end else if (crc_nxt != {rx_byte, newer_r}) begin
        result.status = rtufc_pkg::ST_BAD_CRC;
      end else if (plen > CMP_W'(max_payload_r)) begin
        result.status = rtufc_pkg::ST_OVERFLOW;
      end else begin
        result.status      = rtufc_pkg::ST_GOOD;
        result.payload_len = plen[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= rtufc_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= rtufc_pkg::CRC_INIT;
      cnt_r <= '0;
    end else if (step) begin
      if (frame_end) begin
        crc_r <= rtufc_pkg::CRC_INIT;
        cnt_r <= '0;
      end else begin
        crc_r <= crc_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (first_byte) begin
        unit_r <= rx_byte;
      end
      if (second_byte) begin
        func_r <= rx_byte;
      end
      if (in_body) begin
        older_r <= newer_r;
        newer_r <= rx_byte;
      end
    end
  end

endmodule

>>> design/rtufc_out_reg.sv
// ----------------------------------------------------------------------------
// rtufc_out_reg
// Result register; loads whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module rtufc_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load_valid,
  output logic                    load_ready,
  input  rtufc_pkg::rtufc_result_t load_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rtufc_pkg::rtufc_result_t out_data
);

  logic                     valid_r;
  rtufc_pkg::rtufc_result_t data_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule

>>> design/rtu_frame_checker.sv
// ----------------------------------------------------------------------------
// rtu_frame_checker
// Receive-side RTU frame checker: CRC-16, payload release and frame status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | rx_byte, frame_end
//  out_    | output    | out_valid/out_ready | payload_byte ... status
//  cfg_    | input     | cfg_wr_en (no wait) | cfg_wr_data = max_payload
//
//  One byte per cycle while out_ is not stalled; each transfer on in_ gives
//  exactly one out_ transfer, through the result register. The byte-wide
//  CRC update feeding the compare against the received CRC sets the
//  combinational depth. Synchronous active-low reset clears the count and
//  the result valid flag, sets the CRC to FFFF; max_payload returns to 252.
//  A stalled out_ holds its result; in_ is still taken in the same cycle the
//  held result is drained.
// ----------------------------------------------------------------------------
`include "rtu_frame_checker_macros.svh"

module rtu_frame_checker #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // receive bytes
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_end,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_valid,
  output logic       out_frame_done,
  output logic [7:0] out_unit_id,
  output logic [7:0] out_func_code,
  output logic [7:0] out_payload_len,
  output logic [1:0] out_status
);

  rtufc_pkg::rtufc_result_t step_result;
  rtufc_pkg::rtufc_result_t out_data;
  logic                     in_xfer;

  // Advance frame state on every input transfer.
  assign in_xfer = in_valid && in_ready;

  rtufc_frame_state #(
    .MAX_FRAME (MAX_FRAME)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (in_xfer),
    .rx_byte     (in_rx_byte),
    .frame_end   (in_frame_end),
    .result      (step_result)
  );

  // Hold the result until the sink takes it.
  rtufc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_valid),
    .load_ready (in_ready),
    .load_data  (step_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_valid = out_data.payload_valid;
  assign out_frame_done    = out_data.frame_done;
  assign out_unit_id       = out_data.unit_id;
  assign out_func_code     = out_data.func_code;
  assign out_payload_len   = out_data.payload_len;
  assign out_status        = out_data.status;

  // A stalled result blocks new input.
  `RTUFC_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)
  // Every input transfer shows up as a result next cycle.
  `RTUFC_ASSERT_NEXT(a_xfer_gives_result, clk, rst_n, in_xfer, out_valid)
  // Only a good frame reports a length.
  `RTUFC_ASSERT_NOW(a_len_only_good, clk, rst_n, out_valid && out_status != rtufc_pkg::ST_GOOD, out_payload_len == 8'h00)
  // Status is only reported at frame end.
  `RTUFC_ASSERT_NOW(a_status_at_end, clk, rst_n, out_valid && !out_frame_done, out_status == rtufc_pkg::ST_GOOD)

endmodule
